[hdl/i2cbs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; the controller, datapath, top level and checker import this package.
package i2cbs_pkg;

    // Bus action codes carried on the command channel
    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_STOP    = 3'd1,
        ACT_TX_BYTE = 3'd2,
        ACT_RX_BYTE = 3'd3,
        ACT_TX_ACK  = 3'd4,
        ACT_RX_ACK  = 3'd5
    } action_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Source of the SDA level for a phase that drives SDA
    typedef enum logic [1:0] {
        SDA_HIGH,
        SDA_LOW,
        SDA_TX,
        SDA_ACK
    } sda_src_t;

    // Width of the phase counter (longest action has 24 phases)
    localparam int PHASE_W = 5;

    // Index of the final phase of each action
    localparam logic [PHASE_W-1:0] PH_START_LAST = 5'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_LAST  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_TX_LAST    = 5'd23;
    localparam logic [PHASE_W-1:0] PH_RX_LAST    = 5'd16;
    localparam logic [PHASE_W-1:0] PH_ACK_LAST   = 5'd2;

    // Controller to datapath command bundle
    typedef struct packed {
        logic     load;      // capture command payload
        logic     step;      // produce one pin phase
        logic     scl_we;
        logic     scl_val;
        logic     sda_we;
        sda_src_t sda_src;
        logic     show_rx;   // present received byte
        logic     show_ack;  // present sampled acknowledge
        logic     last;
    } dp_cmd_t;

    // Datapath to controller status bundle
    typedef struct packed {
        logic slot_free;     // output register can take a phase this cycle
    } dp_stat_t;

endpackage

[hdl/i2cbs_cmd_if.sv]
// Command channel: one bus action per transfer.
// Depends on nothing.
interface i2cbs_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] line_bits;

    modport source (output valid, action, tx_byte, ack_out, line_bits, input ready);
    modport sink   (input valid, action, tx_byte, ack_out, line_bits, output ready);
endinterface

[hdl/i2cbs_pin_if.sv]
// Pin phase channel: one SCL/SDA phase per transfer.
// Depends on nothing.
interface i2cbs_pin_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       last;

    modport source (output valid, scl, sda_out, rx_byte, ack_in, last, input ready);
    modport sink   (input valid, scl, sda_out, rx_byte, ack_in, last, output ready);
endinterface

[hdl/i2cbs_ctrl.sv]
// Sequencer controller: state machine, phase counters and per-phase decode.
// Depends on i2cbs_pkg.
module i2cbs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          in_action,
    output logic                in_ready,
    input  i2cbs_pkg::dp_stat_t stat,
    output i2cbs_pkg::dp_cmd_t  ctl
);
    import i2cbs_pkg::*;

    state_t               state_reg, state_next;
    action_t              action_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [1:0]           sub_reg;
    logic                 accept;
    logic                 step;
    logic                 known_action;
    dp_cmd_t              dec;

    assign known_action = (in_action <= 3'(ACT_RX_ACK));
    assign step         = (state_reg == ST_RUN) && stat.slot_free;
    assign in_ready     = (state_reg == ST_IDLE) || (step && dec.last);
    assign accept       = in_valid && in_ready;

    // Decode the pin change for the current phase
    always_comb
    begin
        dec          = '0;
        dec.sda_src  = SDA_HIGH;
        case (action_reg)
            ACT_START:
            begin
                case (phase_reg)
                    5'd0:    begin dec.sda_we = 1'b1; dec.sda_src = SDA_HIGH; end
                    5'd1:    begin dec.scl_we = 1'b1; dec.scl_val = 1'b1; end
                    5'd2:    begin dec.sda_we = 1'b1; dec.sda_src = SDA_LOW; end
                    default: begin dec.scl_we = 1'b1; dec.scl_val = 1'b0; end
                endcase
                dec.last = (phase_reg == PH_START_LAST);
            end
            ACT_STOP:
            begin
                case (phase_reg)
                    5'd0:    begin dec.sda_we = 1'b1; dec.sda_src = SDA_LOW; end
                    5'd1:    begin dec.scl_we = 1'b1; dec.scl_val = 1'b1; end
                    default: begin dec.sda_we = 1'b1; dec.sda_src = SDA_HIGH; end
                endcase
                dec.last = (phase_reg == PH_STOP_LAST);
            end
            ACT_TX_BYTE:
            begin
                case (sub_reg)
                    2'd0:    begin dec.sda_we = 1'b1; dec.sda_src = SDA_TX; end
                    2'd1:    begin dec.scl_we = 1'b1; dec.scl_val = 1'b1; end
                    default: begin dec.scl_we = 1'b1; dec.scl_val = 1'b0; end
                endcase
                dec.last = (phase_reg == PH_TX_LAST);
            end
            ACT_RX_BYTE:
            begin
                if (phase_reg == '0)
                begin
                    dec.sda_we  = 1'b1;
                    dec.sda_src = SDA_HIGH;
                end
                else
                begin
                    dec.scl_we  = 1'b1;
                    dec.scl_val = phase_reg[0];
                end
                dec.last    = (phase_reg == PH_RX_LAST);
                dec.show_rx = dec.last;
            end
            ACT_TX_ACK, ACT_RX_ACK:
            begin
                case (phase_reg)
                    5'd0:
                    begin
                        dec.sda_we  = 1'b1;
                        dec.sda_src = (action_reg == ACT_TX_ACK) ? SDA_ACK : SDA_HIGH;
                    end
                    5'd1:    begin dec.scl_we = 1'b1; dec.scl_val = 1'b1; end
                    default: begin dec.scl_we = 1'b1; dec.scl_val = 1'b0; end
                endcase
                dec.last     = (phase_reg == PH_ACK_LAST);
                dec.show_ack = dec.last && (action_reg == ACT_RX_ACK);
            end
            default: ;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && known_action)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step && dec.last)
                    state_next = (in_valid && known_action) ? ST_RUN : ST_IDLE;
            end
        endcase
    end

    // Command outputs to the datapath
    always_comb
    begin
        ctl      = dec;
        ctl.load = accept;
        ctl.step = step;
    end

    // State and phase counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            action_reg <= ACT_START;
            phase_reg  <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                action_reg <= action_t'(in_action);
                phase_reg  <= '0;
                sub_reg    <= '0;
            end
            else if (step)
            begin
                phase_reg <= phase_reg + 1'b1;
                sub_reg   <= (sub_reg == 2'd2) ? 2'd0 : sub_reg + 1'b1;
            end
        end
    end

endmodule

[hdl/i2cbs_dpath.sv]
// Sequencer datapath: bus levels, payload capture and the output register.
// Depends on i2cbs_pkg.
module i2cbs_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2cbs_pkg::dp_cmd_t  ctl,
    output i2cbs_pkg::dp_stat_t stat,
    input  logic [7:0]          tx_byte,
    input  logic                ack_out,
    input  logic [7:0]          line_bits,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_scl,
    output logic                out_sda,
    output logic [7:0]          out_rx_byte,
    output logic                out_ack_in,
    output logic                out_last
);
    import i2cbs_pkg::*;

    logic       scl_level_reg, scl_level_next;
    logic       sda_level_reg, sda_level_next;
    logic       out_valid_reg;
    logic [7:0] tx_reg;
    logic [7:0] lines_reg;
    logic       ack_reg;
    logic       scl_out_reg, sda_out_reg, ack_in_reg, last_reg;
    logic [7:0] rx_out_reg;

    assign stat.slot_free = !out_valid_reg || out_ready;

    // Pin levels after this phase
    always_comb
    begin
        scl_level_next = ctl.scl_we ? ctl.scl_val : scl_level_reg;
        sda_level_next = sda_level_reg;
        if (ctl.sda_we)
        begin
            case (ctl.sda_src)
                SDA_HIGH: sda_level_next = 1'b1;
                SDA_LOW:  sda_level_next = 1'b0;
                SDA_TX:   sda_level_next = tx_reg[7];
                SDA_ACK:  sda_level_next = ack_reg;
                default:  sda_level_next = 1'b1;
            endcase
        end
    end

    // Bus levels and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_level_reg <= 1'b1;
            sda_level_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.step)
            begin
                scl_level_reg <= scl_level_next;
                sda_level_reg <= sda_level_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture payload, shift data out, load the phase register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tx_reg    <= tx_byte;
            lines_reg <= line_bits;
            ack_reg   <= ack_out;
        end
        else if (ctl.step && ctl.sda_we && (ctl.sda_src == SDA_TX))
            tx_reg <= {tx_reg[6:0], 1'b0};

        if (ctl.step)
        begin
            scl_out_reg <= scl_level_next;
            sda_out_reg <= sda_level_next;
            rx_out_reg  <= ctl.show_rx ? lines_reg : 8'h00;
            ack_in_reg  <= ctl.show_ack && lines_reg[7];
            last_reg    <= ctl.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_scl     = scl_out_reg;
    assign out_sda     = sda_out_reg;
    assign out_rx_byte = rx_out_reg;
    assign out_ack_in  = ack_in_reg;
    assign out_last    = last_reg;

endmodule

[hdl/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer: one bus action in, one SCL/SDA phase out per cycle.
// Phases per action: start 4, stop 3, send byte 24, receive byte 17, acks 3;
// the phase counter issues one phase per cycle while the output side takes them.
// The first phase passes the controller's action and phase registers, then the output register;
// the next command is taken in the cycle of the final phase. Unused action codes are dropped.
// Reset (rst_n, async low) returns SCL and SDA to released and empties the output.
module i2c_master_bit_sequencer
(
    input logic         clk,
    input logic         rst_n,
    i2cbs_cmd_if.sink   cmd,
    i2cbs_pin_if.source pin
);
    import i2cbs_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Sequence control
    i2cbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_action (cmd.action),
        .in_ready  (cmd.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Pin levels and result register
    i2cbs_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .tx_byte     (cmd.tx_byte),
        .ack_out     (cmd.ack_out),
        .line_bits   (cmd.line_bits),
        .out_ready   (pin.ready),
        .out_valid   (pin.valid),
        .out_scl     (pin.scl),
        .out_sda     (pin.sda_out),
        .out_rx_byte (pin.rx_byte),
        .out_ack_in  (pin.ack_in),
        .out_last    (pin.last)
    );

endmodule

[hdl/i2cbs_checker.sv]
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2cbs_pkg and the two channel interfaces.
module i2cbs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [2:0] cmd_action,
    input logic       pin_valid,
    input logic       pin_ready,
    input logic       pin_scl,
    input logic       pin_sda,
    input logic [7:0] pin_rx_byte,
    input logic       pin_ack_in,
    input logic       pin_last
);
    import i2cbs_pkg::*;

    // Hold a phase until it is taken
    a_pin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && !pin_ready |=> pin_valid)
        else $error("pin phase dropped before transfer");

    // Received data only on the closing phase
    a_rx_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && !pin_last |-> (pin_rx_byte == 8'h00) && !pin_ack_in)
        else $error("receive data outside closing phase");

    // Acknowledge reported with SCL low on the closing phase
    a_ack_scl_low: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && pin_ack_in |-> pin_last && !pin_scl)
        else $error("acknowledge shown on wrong phase");

    // An action that ends with SCL high is a stop and releases SDA
    a_stop_release: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && pin_last && pin_scl |-> pin_sda)
        else $error("action ended with SCL high and SDA held low");

    // An accepted known action is followed by a valid phase on the output
    a_phase_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action <= 3'(ACT_RX_ACK)) |=> ##1 pin_valid)
        else $error("no phase after accepted action");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_action  (cmd.action),
    .pin_valid   (pin.valid),
    .pin_ready   (pin.ready),
    .pin_scl     (pin.scl),
    .pin_sda     (pin.sda_out),
    .pin_rx_byte (pin.rx_byte),
    .pin_ack_in  (pin.ack_in),
    .pin_last    (pin.last)
);
